>>> hw/rtl/tirp_pkg.sv
// ----------------------------------------------------------------------------
// tirp_pkg - shared types and codes of the telnet receive parser
// Telnet command and option codes, parse modes, result kinds and the
// per-channel state and result word layouts.
// ----------------------------------------------------------------------------
package tirp_pkg;

	// Telnet command bytes
	localparam logic [7:0] CMD_IAC  = 8'd255;
	localparam logic [7:0] CMD_DONT = 8'd254;
	localparam logic [7:0] CMD_DO   = 8'd253;
	localparam logic [7:0] CMD_WONT = 8'd252;
	localparam logic [7:0] CMD_WILL = 8'd251;
	localparam logic [7:0] CMD_SB   = 8'd250;
	localparam logic [7:0] CMD_EL   = 8'd248;
	localparam logic [7:0] CMD_EC   = 8'd247;
	localparam logic [7:0] CMD_AYT  = 8'd246;
	localparam logic [7:0] CMD_IP   = 8'd244;
	localparam logic [7:0] CMD_BRK  = 8'd243;
	localparam logic [7:0] CMD_DM   = 8'd242;
	localparam logic [7:0] CMD_SE   = 8'd240;
	localparam logic [7:0] CMD_EOR  = 8'd239;

	// Option codes
	localparam logic [7:0] OPT_ECHO     = 8'd1;
	localparam logic [7:0] OPT_SGA      = 8'd3;
	localparam logic [7:0] OPT_NAWS     = 8'd31;
	localparam logic [7:0] OPT_LINEMODE = 8'd34;

	// Characters
	localparam logic [7:0] CHR_NUL = 8'd0;
	localparam logic [7:0] CHR_ETX = 8'h03;
	localparam logic [7:0] CHR_BS  = 8'd8;
	localparam logic [7:0] CHR_CR  = 8'd13;

	// Parse modes
	localparam logic [2:0] MODE_DATA  = 3'd0;
	localparam logic [2:0] MODE_IAC   = 3'd1;
	localparam logic [2:0] MODE_WILL  = 3'd2;
	localparam logic [2:0] MODE_WONT  = 3'd3;
	localparam logic [2:0] MODE_DO    = 3'd4;
	localparam logic [2:0] MODE_DONT  = 3'd5;
	localparam logic [2:0] MODE_SB    = 3'd6;
	localparam logic [2:0] MODE_SBIAC = 3'd7;

	// Result kinds
	localparam logic [2:0] KIND_CONSUMED = 3'd0;
	localparam logic [2:0] KIND_CHAR     = 3'd1;
	localparam logic [2:0] KIND_REPLY    = 3'd2;
	localparam logic [2:0] KIND_MESSAGE  = 3'd3;
	localparam logic [2:0] KIND_DATAMARK = 3'd4;
	localparam logic [2:0] KIND_SUBBEGIN = 3'd5;
	localparam logic [2:0] KIND_SUBEND   = 3'd6;
	localparam logic [2:0] KIND_EOR      = 3'd7;

	// Canned message identifiers
	localparam logic [1:0] MSG_AYT = 2'd0;
	localparam logic [1:0] MSG_BRK = 2'd1;
	localparam logic [1:0] MSG_IP  = 2'd2;

	// Only the first five subnegotiation bytes are ever looked at (NAWS record)
	localparam int NAWS_BYTES = 5;

	// Result queue depth
	localparam int OUT_DEPTH = 8;

	typedef struct packed {
		logic [2:0]                  mode;
		logic                        after_cr;
		logic [15:0]                 cols;
		logic [15:0]                 rows;
		logic [NAWS_BYTES-1:0][7:0]  naws;
	} state_t;

	localparam int STATE_W = $bits(state_t);

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  char_value;
		logic [7:0]  reply_verb;
		logic [7:0]  reply_option;
		logic [1:0]  message_id;
		logic [15:0] cols;
		logic [15:0] rows;
		logic        last;
	} result_t;

endpackage

>>> hw/rtl/tirp_state_mem.sv
// ----------------------------------------------------------------------------
// tirp_state_mem - per-channel state memory
// Registered synchronous read, write port, per-entry valid bits for reset
// and forwarding of a write that lands on the same edge as a read.
// ----------------------------------------------------------------------------
module tirp_state_mem #(
	parameter int CHANNELS = 8,
	parameter int WORD_W   = 80,
	parameter int IW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [IW-1:0]     rd_idx,
	input  logic              wr_en,
	input  logic [IW-1:0]     wr_idx,
	input  logic [WORD_W-1:0] wr_data,
	output logic [WORD_W-1:0] rd_data
);

	logic [WORD_W-1:0]   mem [CHANNELS];
	logic [CHANNELS-1:0] valid_q;
	logic [WORD_W-1:0]   rdata_q;
	logic                rvalid_q;
	logic                fwd_hit_q;
	logic [WORD_W-1:0]   fwd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		if (rd_en) begin
			rdata_q    <= mem[rd_idx];
			fwd_data_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rvalid_q  <= 1'b0;
			fwd_hit_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_idx] <= 1'b1;
			end
			if (rd_en) begin
				rvalid_q  <= valid_q[rd_idx];
				fwd_hit_q <= wr_en && (wr_idx == rd_idx);
			end
		end
	end

	// a never-written entry reads as its reset value, zero
	assign rd_data = fwd_hit_q ? fwd_data_q : (rvalid_q ? rdata_q : '0);

endmodule

>>> hw/rtl/tirp_parse.sv
// ----------------------------------------------------------------------------
// tirp_parse - telnet parse step
// Next state of one channel and the one or two results of one byte.
// ----------------------------------------------------------------------------
module tirp_parse #(
	parameter int SUB_DEPTH = 16,
	parameter int CW        = $clog2(SUB_DEPTH + 1)
) (
	input  logic                in_range,
	input  logic [7:0]          rx_byte,
	input  tirp_pkg::state_t    cur,
	input  logic [CW-1:0]       cur_count,
	output tirp_pkg::state_t    nxt,
	output logic [CW-1:0]       nxt_count,
	output logic                pair,
	output tirp_pkg::result_t   r0,
	output tirp_pkg::result_t   r1
);
	import tirp_pkg::*;

	logic store;
	logic apply;

	always_comb begin
		nxt       = cur;
		nxt.mode  = MODE_DATA;
		nxt_count = cur_count;
		pair      = 1'b0;
		store     = 1'b0;
		apply     = 1'b0;
		r0        = '0;
		r1        = '0;
		r0.kind   = KIND_CONSUMED;

		case (cur.mode)
			MODE_IAC, MODE_SBIAC: begin
				case (rx_byte)
					CMD_IAC: begin
						if (cur.mode == MODE_SBIAC) begin
							store    = 1'b1;
							nxt.mode = MODE_SB;
						end else begin
							r0.kind       = KIND_CHAR;
							r0.char_value = CMD_IAC;
						end
					end
					CMD_WILL: nxt.mode = MODE_WILL;
					CMD_WONT: nxt.mode = MODE_WONT;
					CMD_DO:   nxt.mode = MODE_DO;
					CMD_DONT: nxt.mode = MODE_DONT;
					CMD_SB: begin
						nxt.mode  = MODE_SB;
						nxt_count = '0;
						r0.kind   = KIND_SUBBEGIN;
					end
					CMD_EL: begin
						r0.kind       = KIND_CHAR;
						r0.char_value = CHR_ETX;
					end
					CMD_EC: begin
						r0.kind       = KIND_CHAR;
						r0.char_value = CHR_BS;
					end
					CMD_AYT: begin
						r0.kind       = KIND_MESSAGE;
						r0.message_id = MSG_AYT;
					end
					CMD_IP: begin
						r0.kind       = KIND_MESSAGE;
						r0.message_id = MSG_IP;
					end
					CMD_BRK: begin
						r0.kind       = KIND_MESSAGE;
						r0.message_id = MSG_BRK;
					end
					CMD_DM:  r0.kind = KIND_DATAMARK;
					CMD_SE: begin
						apply   = 1'b1;
						r0.kind = KIND_SUBEND;
					end
					CMD_EOR: r0.kind = KIND_EOR;
					default: ;
				endcase
			end
			MODE_SB: begin
				if (rx_byte == CMD_IAC) begin
					nxt.mode = MODE_SBIAC;
				end else begin
					nxt.mode = MODE_SB;
					store    = 1'b1;
				end
			end
			MODE_WILL: begin
				r0.kind = KIND_REPLY;
				if (rx_byte == OPT_LINEMODE) begin
					r0.reply_verb   = CMD_DONT;
					r0.reply_option = OPT_LINEMODE;
					pair            = 1'b1;
					r1.kind         = KIND_REPLY;
					r1.reply_verb   = CMD_DO;
					r1.reply_option = OPT_ECHO;
				end else if (rx_byte == OPT_NAWS) begin
					r0.reply_verb   = CMD_DO;
					r0.reply_option = OPT_NAWS;
				end else begin
					r0.reply_verb   = CMD_DONT;
					r0.reply_option = rx_byte;
				end
			end
			MODE_DO: begin
				if (rx_byte == OPT_SGA) begin
					r0.kind         = KIND_REPLY;
					r0.reply_verb   = CMD_WILL;
					r0.reply_option = OPT_SGA;
				end else if (rx_byte != OPT_ECHO) begin
					r0.kind         = KIND_REPLY;
					r0.reply_verb   = CMD_WONT;
					r0.reply_option = rx_byte;
				end
			end
			MODE_WONT: begin
				r0.kind = KIND_REPLY;
				if (rx_byte == OPT_ECHO) begin
					r0.reply_verb   = CMD_WILL;
					r0.reply_option = OPT_ECHO;
				end else begin
					r0.reply_verb   = CMD_WONT;
					r0.reply_option = rx_byte;
				end
			end
			MODE_DONT: ;
			default: begin
				if (rx_byte == CMD_IAC) begin
					nxt.mode = MODE_IAC;
				end else begin
					if (!(rx_byte == CHR_NUL && cur.after_cr)) begin
						r0.kind       = KIND_CHAR;
						r0.char_value = rx_byte;
					end
					nxt.after_cr = (rx_byte == CHR_CR);
				end
			end
		endcase

		// keep only the NAWS bytes; the count still saturates at the buffer depth
		if (store && (cur_count < CW'(SUB_DEPTH))) begin
			for (int i = 0; i < NAWS_BYTES; i++) begin
				if (cur_count == CW'(i)) begin
					nxt.naws[i] = rx_byte;
				end
			end
			nxt_count = cur_count + 1'b1;
		end

		if (apply && (cur.naws[0] == OPT_NAWS)) begin
			nxt.cols = {cur.naws[1], cur.naws[2]};
			nxt.rows = {cur.naws[3], cur.naws[4]};
		end

		r0.cols = nxt.cols;
		r0.rows = nxt.rows;
		r0.last = !pair;
		r1.cols = nxt.cols;
		r1.rows = nxt.rows;
		r1.last = 1'b1;

		if (!in_range) begin
			nxt       = cur;
			nxt_count = cur_count;
			pair      = 1'b0;
			r0        = '0;
			r0.last   = 1'b1;
			r1        = '0;
		end
	end

endmodule

>>> hw/rtl/tirp_out_fifo.sv
// ----------------------------------------------------------------------------
// tirp_out_fifo - result queue
// Takes one or two results a cycle, hands out one a cycle on the stream while out_ready is high.
// ----------------------------------------------------------------------------
module tirp_out_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push0,
	input  logic                push1,
	input  tirp_pkg::result_t   d0,
	input  tirp_pkg::result_t   d1,
	output logic [$clog2(tirp_pkg::OUT_DEPTH+1)-1:0] level,
	output logic                out_valid,
	input  logic                out_ready,
	output tirp_pkg::result_t   head
);
	import tirp_pkg::*;

	localparam int PW = $clog2(OUT_DEPTH);
	localparam int LW = $clog2(OUT_DEPTH + 1);

	result_t       mem_q [OUT_DEPTH];
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [LW-1:0] level_q;
	logic          pop;

	assign out_valid = (level_q != '0);
	assign pop       = out_valid && out_ready;
	assign head      = mem_q[rp_q];
	assign level     = level_q;

	always_ff @(posedge clk) begin
		if (push0) begin
			mem_q[wp_q] <= d0;
		end
		if (push1) begin
			mem_q[wp_q + 1'b1] <= d1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			level_q <= '0;
		end else begin
			wp_q    <= wp_q + PW'(push0) + PW'(push1);
			rp_q    <= rp_q + PW'(pop);
			level_q <= level_q + LW'(push0) + LW'(push1) - LW'(pop);
		end
	end

endmodule

>>> hw/rtl/telnet_iac_receive_parser.sv
// ----------------------------------------------------------------------------
// telnet_iac_receive_parser - multi-channel telnet receive parser
// Per-channel NVT byte parser with IAC command handling, option replies
// and NAWS window size decoding.
// ----------------------------------------------------------------------------
// Takes one received telnet byte per cycle (s_tdata) for the channel given
// on s_tuser and returns one result word per byte, two for a WILL LINEMODE
// request (DONT LINEMODE, then DO ECHO), with tlast on the final word of each
// byte. The sustained rate is one byte per clock; the first result word
// shows on m_tvalid after stage 1 and the result queue. Each channel's parse
// mode, CR flag, subnegotiation count, window size and the first five
// subnegotiation bytes live in one state memory word, read on the accept edge
// and written back on the next edge; a byte for the same channel right behind
// takes the written-back word by forwarding, so no bubble is needed. Results
// go into an eight-word queue; s_tready drops while the queue is too full
// to hold the worst case of two words for each byte in flight, which is what
// sets the pace when the downstream side stalls or two-word replies pile up.
// Reset needs no clearing pass: per-channel valid bits make an unwritten
// entry read as the reset state. Bytes on a channel at or above CHANNELS are
// answered with an all-zero consumed word and change nothing.
// ----------------------------------------------------------------------------
module telnet_iac_receive_parser #(
	parameter int CHANNELS  = 8,
	parameter int SUB_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// input bytes
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic [2:0]  s_tuser,   // [2:0] channel
	// results
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [7:0] char_value, [15:8] reply_verb,
	                               // [23:16] reply_option, [25:24] message_id,
	                               // [41:26] cols, [57:42] rows, [63:58] zero
	output logic [2:0]  m_tuser,   // [2:0] kind
	output logic        m_tlast    // last word of this byte
);
	import tirp_pkg::*;

	localparam int IW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CW     = $clog2(SUB_DEPTH + 1);
	localparam int WORD_W = CW + STATE_W;
	localparam int LW     = $clog2(OUT_DEPTH + 1);

	logic              accept;
	logic              v_s1;
	logic [2:0]        ch_s1;
	logic [7:0]        byte_s1;
	logic              in_range_s1;
	logic [WORD_W-1:0] rd_word;
	logic [WORD_W-1:0] wr_word;
	logic              wr_en;
	state_t            cur;
	state_t            nxt;
	logic [CW-1:0]     cur_count;
	logic [CW-1:0]     nxt_count;
	logic              pair;
	result_t           r0;
	result_t           r1;
	result_t           head;
	logic [LW-1:0]     level;

	// take a byte only if the queue can hold two words for it and the one ahead
	assign s_tready = ({1'b0, level} + (v_s1 ? (LW+1)'(2) : '0)) <= (LW+1)'(OUT_DEPTH - 2);
	assign accept   = s_tvalid && s_tready;

	// stage 1: byte whose state word is being read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_s1   <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

	assign in_range_s1 = int'(ch_s1) < CHANNELS;

	tirp_state_mem #(
		.CHANNELS (CHANNELS),
		.WORD_W   (WORD_W)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_idx  (IW'(s_tuser)),
		.wr_en   (wr_en),
		.wr_idx  (IW'(ch_s1)),
		.wr_data (wr_word),
		.rd_data (rd_word)
	);

	assign cur_count = rd_word[WORD_W-1 -: CW];
	assign cur       = state_t'(rd_word[STATE_W-1:0]);

	tirp_parse #(
		.SUB_DEPTH (SUB_DEPTH)
	) u_parse (
		.in_range  (in_range_s1),
		.rx_byte   (byte_s1),
		.cur       (cur),
		.cur_count (cur_count),
		.nxt       (nxt),
		.nxt_count (nxt_count),
		.pair      (pair),
		.r0        (r0),
		.r1        (r1)
	);

	// write back the updated word; out-of-range channels leave memory alone
	assign wr_en   = v_s1 && in_range_s1;
	assign wr_word = {nxt_count, nxt};

	tirp_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push0     (v_s1),
		.push1     (v_s1 && pair),
		.d0        (r0),
		.d1        (r1),
		.level     (level),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.head      (head)
	);

	assign m_tdata = {6'd0, head.rows, head.cols, head.message_id,
	                  head.reply_option, head.reply_verb, head.char_value};
	assign m_tuser = head.kind;
	assign m_tlast = head.last;

	// the queue never takes more words than it has room for
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> ({1'b0, level} + (pair ? (LW+1)'(2) : (LW+1)'(1))) <= (LW+1)'(OUT_DEPTH))
		else $error("result queue overflow");

	// two words come only from a WILL LINEMODE request
	a_pair_source: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && pair) |-> (cur.mode == MODE_WILL && byte_s1 == OPT_LINEMODE))
		else $error("two-word result without WILL LINEMODE");

	// back-to-back bytes on one channel see the state just written
	a_forward: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && in_range_s1 && $past(v_s1 && in_range_s1) && ch_s1 == $past(ch_s1))
		|-> (cur == $past(nxt) && cur_count == $past(nxt_count)))
		else $error("stale state read for back-to-back bytes");

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the telnet receive parser
// Streams received bytes on random channels, keeps a per-channel model of
// the parse state, window size and subnegotiation buffer, and checks every
// result word field by field while both stream sides idle and stall.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tirp_pkg::*;

	localparam int CHANNELS  = 8;
	localparam int SUB_DEPTH = 16;
	localparam int RUN_LIMIT = 400000;   // cycles before the run is called hung
	localparam int HOLD_LEN  = 300;      // long downstream hold-off, in cycles
	localparam int PHASE_LEN = 450;      // random bytes per idling phase
	localparam int SETTLE    = 20;       // quiet cycles after the last word

	// Idling phases: who stalls, and how often
	typedef enum int {PH_STEADY, PH_SRC_IDLE, PH_SINK_STALL, PH_BOTH} idle_phase_e;

	typedef struct packed {
		logic [2:0] channel;
		logic [7:0] value;
	} rx_item_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = '0;
	logic [2:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;

	telnet_iac_receive_parser #(
		.CHANNELS (CHANNELS),
		.SUB_DEPTH(SUB_DEPTH)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	// Bench copy of each channel's parser state
	logic [2:0]  chan_mode  [CHANNELS];
	logic        chan_cr    [CHANNELS];
	int          chan_fill  [CHANNELS];
	logic [7:0]  chan_sub   [CHANNELS][SUB_DEPTH];
	logic [15:0] chan_cols  [CHANNELS];
	logic [15:0] chan_rows  [CHANNELS];

	rx_item_t    rx_backlog[$];   // bytes waiting to be offered
	result_t     due_words[$];    // result words still to arrive, oldest first
	int          bytes_queued = 0;
	int          bytes_taken  = 0;
	int          bad_words    = 0;
	int          cycles       = 0;
	bit          byte_taken   = 1'b0;
	bit          hold_req     = 1'b0;
	int          hold_left    = 0;
	idle_phase_e phase        = PH_STEADY;

	initial begin
		for (int c = 0; c < CHANNELS; c++) begin
			chan_mode[c] = MODE_DATA;
			chan_cr[c]   = 1'b0;
			chan_fill[c] = 0;
			chan_cols[c] = '0;
			chan_rows[c] = '0;
			for (int i = 0; i < SUB_DEPTH; i++)
				chan_sub[c][i] = '0;
		end
	end

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic bit roll(int pct);
		return $urandom_range(99) < pct;
	endfunction

	function automatic result_t reply_word(logic [7:0] verb, logic [7:0] opt);
		result_t w;
		w = '0;
		w.kind         = KIND_REPLY;
		w.reply_verb   = verb;
		w.reply_option = opt;
		return w;
	endfunction

	// Store one subnegotiation byte; drop it once the buffer is full
	task automatic sub_store(int c, logic [7:0] b);
		if (chan_fill[c] < SUB_DEPTH) begin
			chan_sub[c][chan_fill[c]] = b;
			chan_fill[c]++;
		end
	endtask

	// Advance one channel by one received byte and queue the words it yields
	task automatic parse_byte(logic [2:0] ch, logic [7:0] b);
		result_t    w [2];
		int         n;
		int         c;
		logic [2:0] m;
		c    = ch;
		n    = 1;
		w[0] = '0;
		w[1] = '0;
		if (c >= CHANNELS) begin
			// unknown channel: answer with a bare consumed word, touch nothing
			w[0].last = 1'b1;
			due_words.push_back(w[0]);
			return;
		end
		m = chan_mode[c];
		chan_mode[c] = MODE_DATA;
		w[0].kind = KIND_CONSUMED;
		case (m)
			MODE_IAC, MODE_SBIAC: begin
				// any command but a doubled IAC also closes a subnegotiation
				if (b == CMD_IAC) begin
					if (m == MODE_SBIAC) begin
						sub_store(c, b);
						chan_mode[c] = MODE_SB;
					end else begin
						w[0].kind       = KIND_CHAR;
						w[0].char_value = CMD_IAC;
					end
				end else if (b == CMD_WILL) begin
					chan_mode[c] = MODE_WILL;
				end else if (b == CMD_WONT) begin
					chan_mode[c] = MODE_WONT;
				end else if (b == CMD_DO) begin
					chan_mode[c] = MODE_DO;
				end else if (b == CMD_DONT) begin
					chan_mode[c] = MODE_DONT;
				end else if (b == CMD_SB) begin
					chan_mode[c] = MODE_SB;
					chan_fill[c] = 0;
					w[0].kind    = KIND_SUBBEGIN;
				end else if (b == CMD_EL) begin
					w[0].kind       = KIND_CHAR;
					w[0].char_value = CHR_ETX;
				end else if (b == CMD_EC) begin
					w[0].kind       = KIND_CHAR;
					w[0].char_value = CHR_BS;
				end else if (b == CMD_AYT) begin
					w[0].kind       = KIND_MESSAGE;
					w[0].message_id = MSG_AYT;
				end else if (b == CMD_IP) begin
					w[0].kind       = KIND_MESSAGE;
					w[0].message_id = MSG_IP;
				end else if (b == CMD_BRK) begin
					w[0].kind       = KIND_MESSAGE;
					w[0].message_id = MSG_BRK;
				end else if (b == CMD_DM) begin
					w[0].kind = KIND_DATAMARK;
				end else if (b == CMD_SE) begin
					// NAWS takes bytes 1..4 as they stand, stale or not
					if (chan_sub[c][0] == OPT_NAWS) begin
						chan_cols[c] = {chan_sub[c][1], chan_sub[c][2]};
						chan_rows[c] = {chan_sub[c][3], chan_sub[c][4]};
					end
					w[0].kind = KIND_SUBEND;
				end else if (b == CMD_EOR) begin
					w[0].kind = KIND_EOR;
				end
			end
			MODE_SB: begin
				if (b == CMD_IAC) begin
					chan_mode[c] = MODE_SBIAC;
				end else begin
					chan_mode[c] = MODE_SB;
					sub_store(c, b);
				end
			end
			MODE_WILL: begin
				if (b == OPT_LINEMODE) begin
					w[0] = reply_word(CMD_DONT, OPT_LINEMODE);
					w[1] = reply_word(CMD_DO, OPT_ECHO);
					n    = 2;
				end else if (b == OPT_NAWS) begin
					w[0] = reply_word(CMD_DO, OPT_NAWS);
				end else begin
					w[0] = reply_word(CMD_DONT, b);
				end
			end
			MODE_DO: begin
				if (b == OPT_SGA)
					w[0] = reply_word(CMD_WILL, OPT_SGA);
				else if (b != OPT_ECHO)
					w[0] = reply_word(CMD_WONT, b);
			end
			MODE_WONT: begin
				if (b == OPT_ECHO)
					w[0] = reply_word(CMD_WILL, OPT_ECHO);
				else
					w[0] = reply_word(CMD_WONT, b);
			end
			MODE_DONT: begin
			end
			default: begin
				if (b == CMD_IAC) begin
					chan_mode[c] = MODE_IAC;
				end else begin
					// drop the NUL of a CR NUL pair
					if (!(b == CHR_NUL && chan_cr[c])) begin
						w[0].kind       = KIND_CHAR;
						w[0].char_value = b;
					end
					chan_cr[c] = (b == CHR_CR);
				end
			end
		endcase
		for (int i = 0; i < n; i++) begin
			w[i].cols = chan_cols[c];
			w[i].rows = chan_rows[c];
			w[i].last = (i == n - 1);
			due_words.push_back(w[i]);
		end
	endtask

	task automatic queue_rx(logic [2:0] ch, logic [7:0] b);
		rx_backlog.push_back('{channel: ch, value: b});
		bytes_queued++;
	endtask

	// Queue a byte of a sequence; now and then slip a stray byte in ahead of it
	task automatic queue_seq(logic [2:0] ch, logic [7:0] b);
		if ($urandom_range(19) == 0)
			queue_rx(3'($urandom_range(7)), 8'($urandom_range(255)));
		queue_rx(ch, b);
	endtask

	// Subnegotiation payload byte, doubling an IAC as a client would
	task automatic queue_sub(logic [2:0] ch, logic [7:0] b);
		queue_seq(ch, b);
		if (b == CMD_IAC)
			queue_seq(ch, b);
	endtask

	function automatic logic [7:0] pick_option();
		case ($urandom_range(4))
			0: return OPT_ECHO;
			1: return OPT_SGA;
			2: return OPT_NAWS;
			3: return OPT_LINEMODE;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// One mostly well-formed telnet sequence on a random channel
	task automatic queue_random_sequence();
		logic [2:0] ch;
		int         len;
		int         r;
		logic [7:0] b;
		ch = 3'($urandom_range(7));
		case ($urandom_range(9))
			0, 1: begin
				// plain text with CR, NUL and CR NUL pairs mixed in
				len = $urandom_range(1, 6);
				for (int i = 0; i < len; i++) begin
					r = $urandom_range(9);
					b = (r < 2) ? CHR_CR : (r < 4) ? CHR_NUL : 8'($urandom_range(254));
					queue_seq(ch, b);
				end
			end
			2: begin
				case ($urandom_range(11))
					0: b = CMD_EL;
					1: b = CMD_EC;
					2: b = CMD_AYT;
					3: b = CMD_IP;
					4: b = CMD_BRK;
					5: b = CMD_DM;
					6: b = CMD_EOR;
					7: b = CMD_SE;
					8: b = 8'd249;   // GA
					9: b = 8'd245;   // AO
					10: b = 8'd241;  // NOP
					default: b = 8'($urandom_range(255));
				endcase
				queue_seq(ch, CMD_IAC);
				queue_seq(ch, b);
			end
			3, 4: begin
				queue_seq(ch, CMD_IAC);
				queue_seq(ch, 8'($urandom_range(CMD_WILL, CMD_DONT)));
				queue_seq(ch, pick_option());
			end
			5, 6: begin
				// window size record; mostly four bytes, sometimes short or overlong
				r   = $urandom_range(9);
				len = (r < 7) ? 4 : (r < 9) ? $urandom_range(0, 3) : $urandom_range(5, 20);
				queue_seq(ch, CMD_IAC);
				queue_seq(ch, CMD_SB);
				queue_seq(ch, OPT_NAWS);
				for (int i = 0; i < len; i++)
					queue_sub(ch, 8'($urandom_range(255)));
				queue_seq(ch, CMD_IAC);
				queue_seq(ch, CMD_SE);
			end
			7: begin
				// other subnegotiation, sometimes cut short by a command
				len = $urandom_range(0, 20);
				queue_seq(ch, CMD_IAC);
				queue_seq(ch, CMD_SB);
				queue_seq(ch, pick_option());
				for (int i = 0; i < len; i++)
					queue_sub(ch, 8'($urandom_range(255)));
				queue_seq(ch, CMD_IAC);
				queue_seq(ch, ($urandom_range(3) == 0) ? 8'($urandom_range(239, 254)) : CMD_SE);
			end
			8: begin
				queue_seq(ch, CMD_IAC);
				queue_seq(ch, CMD_IAC);
			end
			default: begin
				len = $urandom_range(1, 4);
				for (int i = 0; i < len; i++)
					queue_rx(3'($urandom_range(7)), 8'($urandom_range(255)));
			end
		endcase
	endtask

	// Hold until every queued byte is taken and every word has come back
	task automatic wait_drained();
		while (bytes_taken != bytes_queued || due_words.size() != 0)
			@(negedge clk);
	endtask

	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			bad_words++;
		end
	endtask

	// Byte source: offer the next byte at the falling edge, idling at random
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || byte_taken)) begin
			if (rx_backlog.size() != 0
			    && !roll(phase == PH_SRC_IDLE ? 75 : phase == PH_BOTH ? 26 : 0)) begin
				s_tvalid <= 1'b1;
				s_tuser  <= rx_backlog[0].channel;
				s_tdata  <= rx_backlog[0].value;
				void'(rx_backlog.pop_front());
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		byte_taken = 1'b0;
	end

	// Result sink: stall at random, and hold off entirely while asked to
	always @(negedge clk) begin
		if (arst_n)
			m_tready <= (hold_left == 0)
			            && !roll(phase == PH_SINK_STALL ? 75 : phase == PH_BOTH ? 26 : 0);
	end

	// Long downstream hold-off, counted here so the source keeps running
	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_LEN;
			hold_req  = 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
		end
	end

	// Predict on each accepted byte, then check each accepted word
	always @(posedge clk) begin : watch_words
		result_t w;
		if (arst_n && s_tvalid && s_tready) begin
			parse_byte(s_tuser, s_tdata);
			bytes_taken++;
			byte_taken = 1'b1;
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (due_words.size() == 0) begin
				$error("unexpected result word: kind %0d, data %h", m_tuser, m_tdata);
				bad_words++;
			end else begin
				w = due_words.pop_front();
				check_field("kind",         w.kind,         m_tuser);
				check_field("char_value",   w.char_value,   m_tdata[7:0]);
				check_field("reply_verb",   w.reply_verb,   m_tdata[15:8]);
				check_field("reply_option", w.reply_option, m_tdata[23:16]);
				check_field("message_id",   w.message_id,   m_tdata[25:24]);
				check_field("cols",         w.cols,         m_tdata[41:26]);
				check_field("rows",         w.rows,         m_tdata[57:42]);
				check_field("pad",          0,              m_tdata[63:58]);
				check_field("last",         w.last,         m_tlast);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > RUN_LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: text edges, CR NUL, doubled IAC, LINEMODE pair, SGA,
		// short NAWS record on a fresh buffer, canned messages and EOR
		queue_rx(3'd0, 8'h41);
		queue_rx(3'd0, CHR_NUL);
		queue_rx(3'd0, CHR_CR);
		queue_rx(3'd0, CHR_NUL);
		queue_rx(3'd0, 8'd254);
		queue_rx(3'd0, CMD_IAC);
		queue_rx(3'd0, CMD_IAC);
		queue_rx(3'd0, CMD_IAC);
		queue_rx(3'd0, CMD_WILL);
		queue_rx(3'd0, OPT_LINEMODE);
		queue_rx(3'd7, CMD_IAC);
		queue_rx(3'd7, CMD_DO);
		queue_rx(3'd7, OPT_SGA);
		queue_rx(3'd5, CMD_IAC);
		queue_rx(3'd5, CMD_SB);
		queue_rx(3'd5, OPT_NAWS);
		queue_rx(3'd5, 8'd1);
		queue_rx(3'd5, CMD_IAC);
		queue_rx(3'd5, CMD_SE);
		queue_rx(3'd3, CMD_IAC);
		queue_rx(3'd3, CMD_AYT);
		queue_rx(3'd3, CMD_IAC);
		queue_rx(3'd3, CMD_IP);
		queue_rx(3'd2, CMD_IAC);
		queue_rx(3'd2, CMD_EOR);
		wait_drained();

		// Random sequences, one idling phase at a time; drain in between
		for (int p = PH_STEADY; p <= PH_BOTH; p++) begin
			@(posedge clk);
			phase = idle_phase_e'(p);
			if (phase == PH_STEADY || phase == PH_BOTH)
				hold_req = 1'b1;
			while (bytes_queued < 25 + PHASE_LEN * (p + 1))
				queue_random_sequence();
			wait_drained();
		end

		repeat (SETTLE) @(negedge clk);
		if (bad_words == 0 && due_words.size() == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/tirp_pkg.sv
hw/rtl/tirp_state_mem.sv
hw/rtl/tirp_parse.sv
hw/rtl/tirp_out_fifo.sv
hw/rtl/telnet_iac_receive_parser.sv
tb/sv/tb_top.sv
